FILE: rtl/bhpq_pkg.sv
// Shared types, constants and the key ordering function for the binary heap queue.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package bhpq_pkg;

   // Storage sizing
   localparam int CAPACITY = 128;
   localparam int POS_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KID_W    = POS_W + 2;
   localparam int KEY_W    = 32;
   localparam int OCC_W    = 8;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [POS_W-1:0]        pos_type;
   typedef logic [CNT_W-1:0]        cnt_type;
   typedef logic [KID_W-1:0]        kid_type;
   typedef logic [OCC_W-1:0]        occ_type;

   localparam key_type KEY_MAX = 32'sh7FFF_FFFF;

   // Request opcodes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;

   // Response status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // Response payload selection
   localparam logic [1:0] RES_ZERO  = 2'd0;
   localparam logic [1:0] RES_EMPTY = 2'd1;
   localparam logic [1:0] RES_FULL  = 2'd2;
   localparam logic [1:0] RES_TOP   = 2'd3;

   // Memory read address selection
   localparam logic [1:0] RD_ROOT_LAST = 2'd0;
   localparam logic [1:0] RD_PARENT    = 2'd1;
   localparam logic [1:0] RD_KIDS      = 2'd2;

   typedef struct packed {
      logic       load_insert;
      logic       load_remove;
      logic       load_peek;
      logic [1:0] rd_sel;
      logic       up_move;
      logic       down_move;
      logic       write_key;
      logic       load_rsp;
      logic [1:0] rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic has_kid;
      logic up_go;
      logic down_go;
   } dp_stat_type;

   // True when a sits strictly above b in the selected order
   function automatic logic key_before(input key_type a, input key_type b,
                                       input logic max_order);
      key_before = max_order ? (a > b) : (a < b);
   endfunction

endpackage

FILE: rtl/bhpq_datapath.sv
// Heap datapath: key memory, sift registers, comparators and response registers.
// Depends on bhpq_pkg; driven by bhpq_controller commands.
`timescale 1ns / 1ps

module bhpq_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  bhpq_pkg::cmd_type     cmd,
   output bhpq_pkg::dp_stat_type stat,
   input  bhpq_pkg::key_type     req_key_value,
   input  logic                  csr_we,
   input  logic                  csr_heap_order,
   output bhpq_pkg::key_type     rsp_top_value,
   output logic [1:0]            rsp_status,
   output bhpq_pkg::occ_type     rsp_occupancy
);

   bhpq_pkg::key_type key_mem [bhpq_pkg::CAPACITY];

   logic              order_ff, order_in;
   bhpq_pkg::cnt_type count_ff, count_in;
   bhpq_pkg::pos_type pos_ff, pos_in;
   bhpq_pkg::key_type key_ff, key_in;
   bhpq_pkg::key_type top_ff, top_in;
   bhpq_pkg::key_type rd_a_ff, rd_b_ff;
   bhpq_pkg::key_type rsp_top_ff, rsp_top_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   bhpq_pkg::occ_type rsp_occ_ff, rsp_occ_in;

   bhpq_pkg::pos_type parent, addr_a, addr_b;
   bhpq_pkg::kid_type left_kid, right_kid, pick_idx, count_ext;
   logic              right_ok, use_b, mem_we;
   bhpq_pkg::key_type pick_val, wdata;

   assign parent    = bhpq_pkg::pos_type'((pos_ff - bhpq_pkg::pos_type'(1)) >> 1);
   assign left_kid  = (bhpq_pkg::kid_type'(pos_ff) << 1) | bhpq_pkg::kid_type'(1);
   assign right_kid = left_kid + bhpq_pkg::kid_type'(1);
   assign count_ext = bhpq_pkg::kid_type'(count_ff);
   assign right_ok  = right_kid < count_ext;

   // Better of the two children, left wins ties
   assign use_b    = right_ok && bhpq_pkg::key_before(rd_b_ff, rd_a_ff, order_ff);
   assign pick_val = use_b ? rd_b_ff : rd_a_ff;
   assign pick_idx = use_b ? right_kid : left_kid;

   assign stat.full     = count_ff == bhpq_pkg::cnt_type'(bhpq_pkg::CAPACITY);
   assign stat.empty    = count_ff == '0;
   assign stat.pos_zero = pos_ff == '0;
   assign stat.has_kid  = left_kid < count_ext;
   assign stat.up_go    = bhpq_pkg::key_before(key_ff, rd_a_ff, order_ff);
   assign stat.down_go  = bhpq_pkg::key_before(pick_val, key_ff, order_ff);

   always_comb begin
      unique case (cmd.rd_sel)
         bhpq_pkg::RD_ROOT_LAST: begin
            addr_a = '0;
            addr_b = bhpq_pkg::pos_type'(count_ff - bhpq_pkg::cnt_type'(1));
         end
         bhpq_pkg::RD_PARENT: begin
            addr_a = parent;
            addr_b = parent;
         end
         bhpq_pkg::RD_KIDS: begin
            addr_a = bhpq_pkg::pos_type'(left_kid);
            addr_b = bhpq_pkg::pos_type'(right_kid);
         end
         default: begin
            addr_a = '0;
            addr_b = '0;
         end
      endcase
   end

   // Hole-based sift: the moving key lives in key_ff and lands once at the end
   assign mem_we = cmd.up_move | cmd.down_move | cmd.write_key;
   always_comb begin
      if (cmd.up_move) begin
         wdata = rd_a_ff;
      end else if (cmd.down_move) begin
         wdata = pick_val;
      end else begin
         wdata = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[pos_ff] <= wdata;
      end
      rd_a_ff <= key_mem[addr_a];
      rd_b_ff <= key_mem[addr_b];
   end

   always_comb begin
      order_in = csr_we ? csr_heap_order : order_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      key_in   = key_ff;
      top_in   = top_ff;
      if (cmd.load_insert) begin
         key_in   = req_key_value;
         pos_in   = bhpq_pkg::pos_type'(count_ff);
         count_in = count_ff + bhpq_pkg::cnt_type'(1);
      end
      if (cmd.load_remove) begin
         top_in   = rd_a_ff;
         key_in   = rd_b_ff;
         pos_in   = '0;
         count_in = count_ff - bhpq_pkg::cnt_type'(1);
      end
      if (cmd.load_peek) begin
         top_in = rd_a_ff;
      end
      if (cmd.up_move) begin
         pos_in = parent;
      end
      if (cmd.down_move) begin
         pos_in = bhpq_pkg::pos_type'(pick_idx);
      end
   end

   always_comb begin
      rsp_top_in    = rsp_top_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (cmd.load_rsp) begin
         rsp_occ_in = bhpq_pkg::occ_type'(count_ff);
         unique case (cmd.rsp_kind)
            bhpq_pkg::RES_ZERO: begin
               rsp_top_in    = '0;
               rsp_status_in = bhpq_pkg::STAT_OK;
            end
            bhpq_pkg::RES_EMPTY: begin
               rsp_top_in    = bhpq_pkg::KEY_MAX;
               rsp_status_in = bhpq_pkg::STAT_EMPTY;
            end
            bhpq_pkg::RES_FULL: begin
               rsp_top_in    = '0;
               rsp_status_in = bhpq_pkg::STAT_FULL;
            end
            bhpq_pkg::RES_TOP: begin
               rsp_top_in    = top_ff;
               rsp_status_in = bhpq_pkg::STAT_OK;
            end
            default: begin
               rsp_top_in    = '0;
               rsp_status_in = bhpq_pkg::STAT_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         order_ff <= order_in;
         count_ff <= count_in;
      end
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      top_ff        <= top_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_top_value = rsp_top_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

FILE: rtl/bhpq_controller.sv
// Heap sequencer: request decode, sift-up / sift-down walk, response handshake.
// Depends on bhpq_pkg; drives bhpq_datapath through cmd_type.
`timescale 1ns / 1ps

module bhpq_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_opcode,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bhpq_pkg::cmd_type     cmd,
   input  bhpq_pkg::dp_stat_type stat
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_TOP    = 3'd1;
   localparam logic [2:0] S_UP_CHK = 3'd2;
   localparam logic [2:0] S_UP_CMP = 3'd3;
   localparam logic [2:0] S_DN_CHK = 3'd4;
   localparam logic [2:0] S_DN_CMP = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] kind_ff, kind_in;
   logic       remove_ff, remove_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.rsp_kind = kind_ff;
      state_in     = state_ff;
      kind_in      = kind_ff;
      remove_in    = remove_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            cmd.rd_sel = bhpq_pkg::RD_ROOT_LAST;
            if (req_valid) begin
               remove_in = req_opcode == bhpq_pkg::OP_REMOVE;
               unique case (req_opcode) inside
                  bhpq_pkg::OP_INSERT: begin
                     if (stat.full) begin
                        kind_in  = bhpq_pkg::RES_FULL;
                        state_in = S_RESP;
                     end else begin
                        cmd.load_insert = 1'b1;
                        kind_in         = bhpq_pkg::RES_ZERO;
                        state_in        = S_UP_CHK;
                     end
                  end
                  bhpq_pkg::OP_REMOVE, bhpq_pkg::OP_PEEK: begin
                     if (stat.empty) begin
                        kind_in  = bhpq_pkg::RES_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        kind_in  = bhpq_pkg::RES_TOP;
                        state_in = S_TOP;
                     end
                  end
                  default: begin
                     kind_in  = bhpq_pkg::RES_ZERO;
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_TOP: begin
            if (remove_ff) begin
               cmd.load_remove = 1'b1;
               state_in        = S_DN_CHK;
            end else begin
               cmd.load_peek = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_UP_CHK: begin
            cmd.rd_sel = bhpq_pkg::RD_PARENT;
            if (stat.pos_zero) begin
               cmd.write_key = 1'b1;
               state_in      = S_RESP;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.up_go) begin
               cmd.up_move = 1'b1;
               state_in    = S_UP_CHK;
            end else begin
               cmd.write_key = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_DN_CHK: begin
            cmd.rd_sel = bhpq_pkg::RD_KIDS;
            if (stat.has_kid) begin
               state_in = S_DN_CMP;
            end else begin
               cmd.write_key = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_DN_CMP: begin
            cmd.rd_sel = bhpq_pkg::RD_KIDS;
            if (stat.down_go) begin
               cmd.down_move = 1'b1;
               state_in      = S_DN_CHK;
            end else begin
               cmd.write_key = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= bhpq_pkg::RES_ZERO;
         remove_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
         remove_ff    <= remove_in;
      end
   end

endmodule

FILE: rtl/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue.
// Depends on bhpq_pkg, bhpq_controller and bhpq_datapath.
`timescale 1ns / 1ps
//
// Usage:
//  - req_ channel: one request per handshake, req_opcode (insert, remove top, peek top,
//    code 3 does nothing) with req_key_value used only by insert.
//  - rsp_ channel: exactly one response per request, in order: rsp_top_value,
//    rsp_status (ok / empty / full) and rsp_occupancy after the request.
//  - csr_ channel: csr_heap_order, 0 = min on top, 1 = max on top. Always ready;
//    write it only while no request is in flight.
// Timing: one request at a time. Each tree level of the heap walk is a registered
// memory read, then a compare and write back. An insert walks up from the new slot
// until its key stops or reaches the root; a remove loads the root and last entry,
// then walks down until the key stops or reaches a leaf. Peek loads the root;
// rejected, empty and no-op requests go straight to the response.
// The next request is taken as soon as the current one has moved its response
// into the output register; a stalled rsp_ready holds the response there and the
// following request then waits before its own response is loaded.
// Reset: synchronous; clears the entry count, order bit and handshake state.
// No memory clearing pass: only slots below the entry count are ever used.
//

module binary_heap_priority_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_opcode,
   input  logic signed [31:0]       req_key_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [31:0]       rsp_top_value,
   output logic [1:0]               rsp_status,
   output logic [7:0]               rsp_occupancy,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_heap_order
);

   bhpq_pkg::cmd_type     cmd;
   bhpq_pkg::dp_stat_type stat;

   // Configuration is a single flop; always accept the request
   assign csr_ready = 1'b1;

   bhpq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_opcode(req_opcode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   bhpq_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_key_value (req_key_value),
      .csr_we        (csr_valid & csr_ready),
      .csr_heap_order(csr_heap_order),
      .rsp_top_value (rsp_top_value),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

FILE: rtl/bhpq_checker.sv
// Port-level checks for binary_heap_priority_queue, attached by bind.
// Depends on bhpq_pkg and the top-level port names.
`timescale 1ns / 1ps

module bhpq_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_top_value,
   input logic [1:0]         rsp_status,
   input logic [7:0]         rsp_occupancy
);

   // A stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_top_value)
         && $stable(rsp_status) && $stable(rsp_occupancy))
      else $error("response changed while stalled");

   // Empty report returns the fill key and an empty heap
   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bhpq_pkg::STAT_EMPTY |->
         rsp_top_value == bhpq_pkg::KEY_MAX && rsp_occupancy == '0)
      else $error("empty response malformed");

   // Rejected insert only when full, with zero key
   a_full_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bhpq_pkg::STAT_FULL |->
         rsp_top_value == '0 &&
         rsp_occupancy == bhpq_pkg::occ_type'(bhpq_pkg::CAPACITY))
      else $error("full response malformed");

   // Occupancy never exceeds capacity
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= bhpq_pkg::occ_type'(bhpq_pkg::CAPACITY))
      else $error("occupancy out of range");

   // No response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind binary_heap_priority_queue bhpq_checker u_checker (.*);

FILE: dv/tb_top.sv
// Self-checking bench for binary_heap_priority_queue: inserts, remove-top, peek and no-op
// requests in both orders, checked against a heap model kept in the bench.
// Depends on rtl/bhpq_pkg.sv and the queue RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] OP_NOP = 2'd3;      // unused code, must change nothing
   localparam int SETTLE_CYCLES   = 24;       // idle wait after the last reply
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_REQUESTS  = 150;

   typedef struct packed {
      bhpq_pkg::key_type top;
      logic [1:0]        status;
      bhpq_pkg::occ_type occ;
   } heap_reply_type;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic [1:0]        req_opcode     = bhpq_pkg::OP_INSERT;
   bhpq_pkg::key_type req_key_value  = '0;
   logic              rsp_ready      = 1'b0;
   logic              csr_valid      = 1'b0;
   logic              csr_heap_order = 1'b0;
   logic              req_ready;
   logic              rsp_valid;
   bhpq_pkg::key_type rsp_top_value;
   logic [1:0]        rsp_status;
   bhpq_pkg::occ_type rsp_occupancy;
   logic              csr_ready;

   // heap model state
   bhpq_pkg::key_type heap_keys [bhpq_pkg::CAPACITY];
   int unsigned       heap_count;
   bit                max_on_top;
   heap_reply_type    pending_replies [$];

   int                error_count  = 0;
   int                burst_left   = 0;
   bit                sender_idles = 1'b1;

   binary_heap_priority_queue u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_key_value  (req_key_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_top_value  (rsp_top_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_heap_order (csr_heap_order)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("tb_top: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------- model
   function automatic bit outranks(bhpq_pkg::key_type a, bhpq_pkg::key_type b);
      return max_on_top ? (a > b) : (a < b);
   endfunction

   // Applies one request to the model heap and returns the reply it owes.
   function automatic heap_reply_type model_request(logic [1:0] op, bhpq_pkg::key_type key);
      heap_reply_type    r;
      int unsigned       pos;
      int unsigned       up;
      int unsigned       kid;
      bhpq_pkg::key_type hold;
      r = '{top: '0, status: bhpq_pkg::STAT_OK, occ: '0};
      case (op)
         bhpq_pkg::OP_INSERT: begin
            if (heap_count >= bhpq_pkg::CAPACITY) begin
               r.status = bhpq_pkg::STAT_FULL;
            end else begin
               heap_keys[heap_count] = key;
               pos = heap_count;
               heap_count++;
               while (pos > 0) begin
                  up = (pos - 1) / 2;
                  if (!outranks(heap_keys[pos], heap_keys[up])) break;
                  hold = heap_keys[pos];
                  heap_keys[pos] = heap_keys[up];
                  heap_keys[up] = hold;
                  pos = up;
               end
            end
         end
         bhpq_pkg::OP_REMOVE, bhpq_pkg::OP_PEEK: begin
            if (heap_count == 0) begin
               r.top = bhpq_pkg::KEY_MAX;
               r.status = bhpq_pkg::STAT_EMPTY;
            end else begin
               r.top = heap_keys[0];
               if (op == bhpq_pkg::OP_REMOVE) begin
                  heap_count--;
                  heap_keys[0] = heap_keys[heap_count];
                  heap_keys[heap_count] = bhpq_pkg::KEY_MAX;
                  pos = 0;
                  forever begin
                     kid = 2 * pos + 1;
                     if (kid >= heap_count) break;
                     if (kid + 1 < heap_count && outranks(heap_keys[kid + 1], heap_keys[kid]))
                        kid = kid + 1;
                     if (!outranks(heap_keys[kid], heap_keys[pos])) break;
                     hold = heap_keys[pos];
                     heap_keys[pos] = heap_keys[kid];
                     heap_keys[kid] = hold;
                     pos = kid;
                  end
               end
            end
         end
         default: ;
      endcase
      r.occ = heap_count[7:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- response side
   // Ready follows a rotating 16-bit pattern, never all zero, swapped every so often;
   // a quarter of the patterns never stall.
   logic [15:0] ready_pattern = 16'hFFFF;
   int          pattern_left  = 0;

   always @(posedge clock) begin
      if (pattern_left == 0) begin
         pattern_left <= $urandom_range(20, 200);
         if ($urandom_range(0, 3) == 0) ready_pattern <= 16'hFFFF;
         else ready_pattern <= 16'($urandom) | 16'h0001;
      end else begin
         pattern_left  <= pattern_left - 1;
         ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
      end
      rsp_ready <= ready_pattern[0];
   end

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_replies
      heap_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response, expected none, got top %0d status %0d occ %0d",
                     $time, rsp_top_value, rsp_status, rsp_occupancy);
         end else begin
            want = pending_replies.pop_front();
            check_field("top_value", want.top, rsp_top_value);
            check_field("status", want.status, rsp_status);
            check_field("occupancy", want.occ, rsp_occupancy);
         end
      end
   end

   // ---------------------------------------------------------------- request side
   // Sends one request; valid is left high when the burst continues so the next
   // call can follow without a bubble.
   task automatic send_request(input logic [1:0] op, input bhpq_pkg::key_type key);
      int gap;
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_key_value <= key;
      do @(posedge clock); while (!req_ready);
      pending_replies = {pending_replies, model_request(op, key)};
      if (sender_idles && burst_left == 0) begin
         burst_left = $urandom_range(0, 15);
         gap        = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else if (burst_left > 0) begin
         burst_left--;
      end
   endtask

   // Drops valid and holds off until every reply has been seen.
   task automatic wait_replies();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   task automatic write_heap_order(input bit order);
      wait_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_heap_order <= order;
      do @(posedge clock); while (!csr_ready);
      max_on_top = order;
      csr_valid <= 1'b0;
   endtask

   function automatic bhpq_pkg::key_type pick_key();
      bhpq_pkg::key_type edges [5] = '{bhpq_pkg::KEY_MAX, 32'sh8000_0000, 32'sd0,
                                       -32'sd1, 32'sd1};
      case ($urandom_range(0, 9))
         0:       return edges[$urandom_range(0, 4)];
         1, 2, 3: return bhpq_pkg::key_type'($urandom_range(0, 15)) - 8;   // many equal keys
         default: return bhpq_pkg::key_type'($urandom);
      endcase
   endfunction

   function automatic logic [1:0] pick_op(int insert_pct);
      int pick;
      if ($urandom_range(0, 99) < insert_pct) return bhpq_pkg::OP_INSERT;
      pick = $urandom_range(0, 19);
      if (pick == 0) return OP_NOP;
      if (pick <= 5) return bhpq_pkg::OP_PEEK;
      return bhpq_pkg::OP_REMOVE;
   endfunction

   // ---------------------------------------------------------------- tests
   // Empty heap, extreme keys, equal keys, the unused code, then drain past empty.
   task automatic test_extremes_min_order();
      bhpq_pkg::key_type keys [9] = '{bhpq_pkg::KEY_MAX, 32'sh8000_0000, 32'sd0, -32'sd1,
                                      32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd7,
                                      32'sd7};
      send_request(bhpq_pkg::OP_PEEK, '0);
      send_request(bhpq_pkg::OP_REMOVE, 32'sh7FFF_FFFF);
      send_request(OP_NOP, -32'sd1);
      foreach (keys[i]) send_request(bhpq_pkg::OP_INSERT, keys[i]);
      send_request(bhpq_pkg::OP_PEEK, 32'sh1234_5678);
      send_request(OP_NOP, '0);
      send_request(bhpq_pkg::OP_INSERT, 32'sd7);
      repeat (11) send_request(bhpq_pkg::OP_REMOVE, '0);
      send_request(bhpq_pkg::OP_PEEK, '0);
   endtask

   // Order flipped with keys still stored: the array is kept, later sifts use max order.
   task automatic test_order_change_holding();
      bhpq_pkg::key_type keys [6] = '{32'sd40, -32'sd5, 32'sd12, 32'sd0, 32'sd99, -32'sd70};
      foreach (keys[i]) send_request(bhpq_pkg::OP_INSERT, keys[i]);
      write_heap_order(1'b1);
      send_request(bhpq_pkg::OP_INSERT, 32'sd7);
      send_request(bhpq_pkg::OP_INSERT, 32'sh7FFF_FFFE);
      send_request(bhpq_pkg::OP_PEEK, '0);
      repeat (9) send_request(bhpq_pkg::OP_REMOVE, '0);
   endtask

   // Fill to capacity, get rejected, drain completely and once more past empty.
   task automatic test_capacity();
      repeat (bhpq_pkg::CAPACITY + 3) send_request(bhpq_pkg::OP_INSERT, pick_key());
      send_request(bhpq_pkg::OP_PEEK, '0);
      repeat (bhpq_pkg::CAPACITY + 1) send_request(bhpq_pkg::OP_REMOVE, pick_key());
   endtask

   // Random phases: order alternates, every fourth phase picked at random; fill bias varies,
   // some phases run without sender gaps, and each phase pauses once mid-way for all replies.
   task automatic test_random_phases();
      int bias_table [3] = '{75, 55, 35};
      int bias;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase % 4 == 3) write_heap_order(bit'($urandom_range(0, 1)));
         else write_heap_order(bit'(phase % 2));
         bias         = bias_table[$urandom_range(0, 2)];
         sender_idles = (phase % 3 != 2);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (n == PHASE_REQUESTS / 2) wait_replies();
            send_request(pick_op(bias), pick_key());
         end
      end
      sender_idles = 1'b1;
   endtask

   initial begin
      foreach (heap_keys[i]) heap_keys[i] = bhpq_pkg::KEY_MAX;
      heap_count = 0;
      max_on_top = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_extremes_min_order();
      test_order_change_holding();
      test_capacity();
      write_heap_order(1'b0);
      test_capacity();
      test_random_phases();

      wait_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
